>>> sv/rchm_pkg.sv
`default_nettype none

package rchm_pkg;

   // Operation codes carried by the request word.
   localparam logic [2:0] OP_ALLOC    = 3'd0;
   localparam logic [2:0] OP_ADD_REF  = 3'd1;
   localparam logic [2:0] OP_DEL_REF  = 3'd2;
   localparam logic [2:0] OP_SET_ROOT = 3'd3;
   localparam logic [2:0] OP_CLR_ROOT = 3'd4;
   localparam logic [2:0] OP_COLLECT  = 3'd5;

   // Status codes returned in the response word.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUP_EDGE  = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_NO_MEM    = 3'd3;
   localparam logic [2:0] ST_NO_SRC    = 3'd4;
   localparam logic [2:0] ST_NO_TGT    = 3'd5;
   localparam logic [2:0] ST_NO_EDGE   = 3'd6;
   localparam logic [2:0] ST_EXHAUSTED = 3'd7;

   // Field widths of the request and response words.
   localparam int OpW    = 3;
   localparam int IdW    = 8;
   localparam int BytesW = 32;
   localparam int DelW   = 9;

   localparam logic [BytesW-1:0] HeapLimitReset = 32'd65536;

endpackage

`default_nettype wire

>>> sv/refcount_cascade_heap_manager_unit.sv
`default_nettype none

// Reference-counting heap manager. A request word is taken when start is high and busy is low;
// exactly one response word follows, shown for a single cycle with rsp_valid high, and it must
// be captured in that cycle. Object state lives in two single-port memories (one entry per id
// holding size, incoming count and flags, and one edge row per id) plus a live bit per id.
// On success a reference operation reads the source's edge row, then updates it and the target's
// entry; a root operation reads and rewrites one entry, and an allocate writes a fresh entry and row.
// A collection, an allocate short of room, and a remove that leaves its target unreferenced,
// sweep the allocated ids in passes, reading the entry of each live id; each deleted object adds
// a walk of its edge row that updates each live target. Passes repeat until one deletes nothing.
// The heap limit register is written through the csr port while busy is low.
module refcount_cascade_heap_manager_unit #(
   parameter int MaxObjects = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rchm_pkg::OpW-1:0]      req_operation,
   input  wire logic [rchm_pkg::IdW-1:0]      req_object_a,
   input  wire logic [rchm_pkg::IdW-1:0]      req_object_b,
   input  wire logic [rchm_pkg::BytesW-1:0]   req_request_bytes,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [rchm_pkg::IdW-1:0]           rsp_new_id,
   output logic [rchm_pkg::BytesW-1:0]        rsp_freed_bytes,
   output logic [rchm_pkg::DelW-1:0]          rsp_deleted_count,
   output logic [rchm_pkg::BytesW-1:0]        rsp_used_bytes,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rchm_pkg::BytesW-1:0]   csr_data
);

   localparam int IdxW   = $clog2(MaxObjects);
   localparam int CtW    = $clog2(MaxObjects + 1);
   localparam int BW     = rchm_pkg::BytesW;
   localparam int CntLo  = BW;
   localparam int RootB  = BW + CtW;
   localparam int DoomB  = BW + CtW + 1;
   localparam int ObjW   = BW + CtW + 2;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISP      = 4'd1;
   localparam logic [3:0] S_EDGE_MOD  = 4'd2;
   localparam logic [3:0] S_TGT_WR    = 4'd3;
   localparam logic [3:0] S_ROOT_WR   = 4'd4;
   localparam logic [3:0] S_SW_RD     = 4'd5;
   localparam logic [3:0] S_SW_CHK    = 4'd6;
   localparam logic [3:0] S_ROW_SCAN  = 4'd7;
   localparam logic [3:0] S_ROW_UPD   = 4'd8;
   localparam logic [3:0] S_ALLOC_CHK = 4'd9;
   localparam logic [3:0] S_ALLOC_WR  = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   // Control and bookkeeping registers.
   logic [3:0]                 state_ff, state_in;
   logic [2:0]                 op_ff, op_in;
   logic [rchm_pkg::IdW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [BW-1:0]              req_ff, req_in;
   logic [BW-1:0]              limit_ff, limit_in;
   logic [BW-1:0]              used_ff, used_in;
   logic [CtW-1:0]             next_id_ff, next_id_in;
   logic [MaxObjects-1:0]      live_ff, live_in;
   logic [CtW-1:0]             idx_ff, idx_in, tpos_ff, tpos_in;
   logic                       pass_del_ff, pass_del_in;
   logic                       collect_mode_ff, collect_mode_in;
   logic [BW-1:0]              cur_size_ff, cur_size_in;
   logic [2:0]                 status_ff, status_in;
   logic [rchm_pkg::IdW-1:0]   new_id_ff, new_id_in;
   logic [BW-1:0]              freed_ff, freed_in;
   logic [rchm_pkg::DelW-1:0]  deleted_ff, deleted_in;

   // Memory ports.
   logic [ObjW-1:0]        obj_mem [MaxObjects];
   logic [ObjW-1:0]        obj_rd_ff;
   logic                   obj_re, obj_we;
   logic [IdxW-1:0]        obj_addr;
   logic [ObjW-1:0]        obj_wdata;
   logic [MaxObjects-1:0]  edge_mem [MaxObjects];
   logic [MaxObjects-1:0]  edge_rd_ff;
   logic                   edge_re, edge_we;
   logic [IdxW-1:0]        edge_addr;
   logic [MaxObjects-1:0]  edge_wdata;
   logic [MaxObjects-1:0]  edge_mod;

   // Decoded views of the request and of the object word just read.
   logic                   a_ok, b_ok;
   logic [IdxW-1:0]        a_idx, b_idx, idx_idx, tpos_idx, new_idx;
   logic [BW-1:0]          free_bytes;
   logic                   short_mem;
   logic [BW-1:0]          rd_size;
   logic [CtW-1:0]         rd_cnt, cnt_dec, cnt_inc;
   logic                   rd_root, rd_doom;
   logic                   idx_end, tpos_end;

   assign a_idx    = IdxW'(a_ff);
   assign b_idx    = IdxW'(b_ff);
   assign idx_idx  = idx_ff[IdxW-1:0];
   assign tpos_idx = tpos_ff[IdxW-1:0];
   assign new_idx  = next_id_ff[IdxW-1:0];
   assign a_ok     = (32'(a_ff) < 32'(MaxObjects)) && live_ff[a_idx];
   assign b_ok     = (32'(b_ff) < 32'(MaxObjects)) && live_ff[b_idx];
   assign idx_end  = (idx_ff == next_id_ff);
   assign tpos_end = (tpos_ff == next_id_ff);

   // Free space saturates at zero when the limit was lowered under the live total.
   assign free_bytes = (limit_ff > used_ff) ? (limit_ff - used_ff) : '0;
   assign short_mem  = (free_bytes < req_ff);

   assign rd_size = obj_rd_ff[BW-1:0];
   assign rd_cnt  = obj_rd_ff[CntLo +: CtW];
   assign rd_root = obj_rd_ff[RootB];
   assign rd_doom = obj_rd_ff[DoomB];
   assign cnt_dec = (rd_cnt != '0) ? (rd_cnt - CtW'(1)) : '0;
   assign cnt_inc = rd_cnt + CtW'(1);

   always_comb begin
      edge_mod = edge_rd_ff;
      edge_mod[b_idx] = (op_ff == rchm_pkg::OP_ADD_REF);
   end

   // Main sequencer.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      req_in          = req_ff;
      limit_in        = limit_ff;
      used_in         = used_ff;
      next_id_in      = next_id_ff;
      live_in         = live_ff;
      idx_in          = idx_ff;
      tpos_in         = tpos_ff;
      pass_del_in     = pass_del_ff;
      collect_mode_in = collect_mode_ff;
      cur_size_in     = cur_size_ff;
      status_in       = status_ff;
      new_id_in       = new_id_ff;
      freed_in        = freed_ff;
      deleted_in      = deleted_ff;
      obj_re          = 1'b0;
      obj_we          = 1'b0;
      obj_addr        = '0;
      obj_wdata       = '0;
      edge_re         = 1'b0;
      edge_we         = 1'b0;
      edge_addr       = '0;
      edge_wdata      = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               limit_in = csr_data;
            end
            if (start) begin
               op_in      = req_operation;
               a_in       = req_object_a;
               b_in       = req_object_b;
               req_in     = req_request_bytes;
               status_in  = rchm_pkg::ST_OK;
               new_id_in  = '0;
               freed_in   = '0;
               deleted_in = '0;
               state_in   = S_DISP;
            end
         end

         S_DISP: begin
            case (op_ff)
               rchm_pkg::OP_ALLOC: begin
                  if (req_ff == '0 || req_ff > limit_ff) begin
                     status_in = rchm_pkg::ST_BAD_SIZE;
                     state_in  = S_DONE;
                  end else if (32'(next_id_ff) >= 32'(MaxObjects)) begin
                     status_in = rchm_pkg::ST_EXHAUSTED;
                     state_in  = S_DONE;
                  end else if (short_mem) begin
                     idx_in          = '0;
                     pass_del_in     = 1'b0;
                     collect_mode_in = 1'b1;
                     state_in        = S_SW_RD;
                  end else begin
                     state_in = S_ALLOC_WR;
                  end
               end
               rchm_pkg::OP_ADD_REF, rchm_pkg::OP_DEL_REF: begin
                  if (!a_ok) begin
                     status_in = rchm_pkg::ST_NO_SRC;
                     state_in  = S_DONE;
                  end else if (!b_ok) begin
                     status_in = rchm_pkg::ST_NO_TGT;
                     state_in  = S_DONE;
                  end else begin
                     edge_re   = 1'b1;
                     edge_addr = a_idx;
                     state_in  = S_EDGE_MOD;
                  end
               end
               rchm_pkg::OP_SET_ROOT, rchm_pkg::OP_CLR_ROOT: begin
                  if (!a_ok) begin
                     status_in = rchm_pkg::ST_NO_SRC;
                     state_in  = S_DONE;
                  end else begin
                     obj_re   = 1'b1;
                     obj_addr = a_idx;
                     state_in = S_ROOT_WR;
                  end
               end
               rchm_pkg::OP_COLLECT: begin
                  idx_in          = '0;
                  pass_del_in     = 1'b0;
                  collect_mode_in = 1'b1;
                  state_in        = S_SW_RD;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Row of the source is in hand: test and update the edge, then fetch the target.
         S_EDGE_MOD: begin
            if (op_ff == rchm_pkg::OP_ADD_REF && edge_rd_ff[b_idx]) begin
               status_in = rchm_pkg::ST_DUP_EDGE;
               state_in  = S_DONE;
            end else if (op_ff == rchm_pkg::OP_DEL_REF && !edge_rd_ff[b_idx]) begin
               status_in = rchm_pkg::ST_NO_EDGE;
               state_in  = S_DONE;
            end else begin
               edge_we    = 1'b1;
               edge_addr  = a_idx;
               edge_wdata = edge_mod;
               obj_re     = 1'b1;
               obj_addr   = b_idx;
               state_in   = S_TGT_WR;
            end
         end

         // Adjust the target's incoming count; an unreferenced non-root target starts a cascade.
         S_TGT_WR: begin
            obj_we   = 1'b1;
            obj_addr = b_idx;
            if (op_ff == rchm_pkg::OP_ADD_REF) begin
               obj_wdata = {rd_doom, rd_root, cnt_inc, rd_size};
               state_in  = S_DONE;
            end else begin
               obj_wdata = {(cnt_dec == '0) && !rd_root, rd_root, cnt_dec, rd_size};
               if (cnt_dec == '0 && !rd_root) begin
                  idx_in          = '0;
                  pass_del_in     = 1'b0;
                  collect_mode_in = 1'b0;
                  state_in        = S_SW_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_ROOT_WR: begin
            obj_we    = 1'b1;
            obj_addr  = a_idx;
            obj_wdata = {rd_doom, (op_ff == rchm_pkg::OP_SET_ROOT), rd_cnt, rd_size};
            state_in  = S_DONE;
         end

         // Sweep over allocated ids; passes repeat until one deletes nothing.
         S_SW_RD: begin
            if (idx_end) begin
               if (pass_del_ff) begin
                  idx_in      = '0;
                  pass_del_in = 1'b0;
               end else if (op_ff == rchm_pkg::OP_ALLOC) begin
                  state_in = S_ALLOC_CHK;
               end else begin
                  state_in = S_DONE;
               end
            end else if (!live_ff[idx_idx]) begin
               idx_in = idx_ff + CtW'(1);
            end else begin
               obj_re   = 1'b1;
               obj_addr = idx_idx;
               state_in = S_SW_CHK;
            end
         end

         S_SW_CHK: begin
            if (collect_mode_ff ? (!rd_root && rd_cnt == '0) : rd_doom) begin
               cur_size_in = rd_size;
               edge_re     = 1'b1;
               edge_addr   = idx_idx;
               tpos_in     = '0;
               state_in    = S_ROW_SCAN;
            end else begin
               idx_in   = idx_ff + CtW'(1);
               state_in = S_SW_RD;
            end
         end

         // Walk the doomed object's edge row, then retire the object.
         S_ROW_SCAN: begin
            if (tpos_end) begin
               live_in[idx_idx] = 1'b0;
               freed_in         = freed_ff + cur_size_ff;
               deleted_in       = deleted_ff + rchm_pkg::DelW'(1);
               used_in          = used_ff - cur_size_ff;
               pass_del_in      = 1'b1;
               idx_in           = idx_ff + CtW'(1);
               state_in         = S_SW_RD;
            end else if (edge_rd_ff[tpos_idx] && live_ff[tpos_idx]) begin
               obj_re   = 1'b1;
               obj_addr = tpos_idx;
               state_in = S_ROW_UPD;
            end else begin
               tpos_in = tpos_ff + CtW'(1);
            end
         end

         S_ROW_UPD: begin
            obj_we    = 1'b1;
            obj_addr  = tpos_idx;
            obj_wdata = {rd_doom || ((cnt_dec == '0) && !rd_root), rd_root, cnt_dec, rd_size};
            tpos_in   = tpos_ff + CtW'(1);
            state_in  = S_ROW_SCAN;
         end

         S_ALLOC_CHK: begin
            if (short_mem) begin
               status_in = rchm_pkg::ST_NO_MEM;
               state_in  = S_DONE;
            end else begin
               state_in = S_ALLOC_WR;
            end
         end

         // New object: fresh entry and empty edge row.
         S_ALLOC_WR: begin
            obj_we           = 1'b1;
            obj_addr         = new_idx;
            obj_wdata        = {1'b0, 1'b0, {CtW{1'b0}}, req_ff};
            edge_we          = 1'b1;
            edge_addr        = new_idx;
            edge_wdata       = '0;
            live_in[new_idx] = 1'b1;
            used_in          = used_ff + req_ff;
            new_id_in        = rchm_pkg::IdW'(next_id_ff);
            next_id_in       = next_id_ff + CtW'(1);
            state_in         = S_DONE;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         limit_ff   <= rchm_pkg::HeapLimitReset;
         used_ff    <= '0;
         next_id_ff <= '0;
         live_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         used_ff    <= used_in;
         next_id_ff <= next_id_in;
         live_ff    <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      req_ff          <= req_in;
      idx_ff          <= idx_in;
      tpos_ff         <= tpos_in;
      pass_del_ff     <= pass_del_in;
      collect_mode_ff <= collect_mode_in;
      cur_size_ff     <= cur_size_in;
      status_ff       <= status_in;
      new_id_ff       <= new_id_in;
      freed_ff        <= freed_in;
      deleted_ff      <= deleted_in;
   end

   // Object memory: size, incoming count, root and doomed flags.
   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[obj_addr] <= obj_wdata;
      end
      if (obj_re) begin
         obj_rd_ff <= obj_mem[obj_addr];
      end
   end

   // Edge memory: one row of outgoing references per object.
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_addr] <= edge_wdata;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_addr];
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign csr_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_DONE);
   assign rsp_status        = status_ff;
   assign rsp_new_id        = new_id_ff;
   assign rsp_freed_bytes   = freed_ff;
   assign rsp_deleted_count = deleted_ff;
   assign rsp_used_bytes    = used_ff;

   // The response word lasts one cycle and the block is then free again.
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response word held longer than one cycle");

   // Work only ends through a response.
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("busy dropped without a response word");

   // Ids are handed out no further than the object count.
   a_id_bound: assert property (@(posedge clock) disable iff (reset)
      32'(next_id_ff) <= 32'(MaxObjects))
      else $error("next id beyond object count");

   // Only a live object is ever retired.
   a_retire_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW_SCAN) && tpos_end |-> live_ff[idx_idx])
      else $error("retiring an object that is not live");

   // A successful allocate counts up the id register by one.
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_WR) |=> (next_id_ff == $past(next_id_ff) + CtW'(1)))
      else $error("allocate did not advance the id");

endmodule

`default_nettype wire
